// ===== rtl/hsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// Half/single float converter package
// Direction codes and the format constants shared by the converter and its
// checker.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  // Direction codes carried by the func field.
  localparam logic FUNC_S2H = 1'b0;  // single to half
  localparam logic FUNC_H2S = 1'b1;  // half to single

  // Single precision exponent limits used when narrowing and widening.
  localparam logic [7:0] S_EXP_SPECIAL  = 8'd255;
  localparam logic [7:0] S_EXP_OVF      = 8'd143;
  localparam logic [7:0] S_EXP_OVF_EDGE = 8'd142;
  localparam logic [7:0] S_EXP_UNF      = 8'd101;
  localparam logic [7:0] S_EXP_UNF_EDGE = 8'd102;
  localparam logic [7:0] S_EXP_DENORM   = 8'd112;
  localparam logic [7:0] S_EXP_SHIFT    = 8'd126;
  localparam logic [7:0] EXP_BIAS_DIFF  = 8'd112;
  localparam logic [7:0] S_EXP_DNRM_LOW = 8'd103;

  localparam logic [22:0] S_MANT_OVF = 23'h7fe000;
  localparam logic [22:0] S_MANT_UNF = 23'h002000;

  // Half precision patterns.
  localparam logic [4:0]  H_EXP_SPECIAL = 5'd31;
  localparam logic [14:0] H_INF         = 15'h7c00;
  localparam logic [15:0] H_QNAN        = 16'h7e00;

  // Single precision patterns.
  localparam logic [30:0] S_INF  = 31'h7f800000;
  localparam logic [31:0] S_QNAN = 32'h7fc00000;

endpackage

// ===== rtl/half_single_float_converter.sv =====
// ----------------------------------------------------------------------------
// Half/single float converter
// Converts IEEE single and half precision bit patterns in either direction.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries func and value_bits. With
//   func at 0 a single pattern is narrowed to half by truncation; with func
//   at 1 the low 16 bits are widened to single exactly. The output channel
//   (out_valid/out_ready) returns result_bits, one item per input item, in
//   order. A half result sits in the low 16 bits with the upper bits zero.
//   The block has an input register and a result register with the
//   conversion logic between them; an accepted item passes through the
//   input register and then the result register, which drives the output.
//   Throughput is one item per cycle while the receiver does not stall; the
//   half denormal normalizer is a ten-input priority encoder inside that single stage.
//   When the receiver stalls, the result register holds its item and the
//   input register fills; in_ready then drops until out_ready returns.
//   A synchronous reset empties both registers; any item in them is dropped,
//   none is kept across it, and there is no other state.
// ----------------------------------------------------------------------------
module half_single_float_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] value_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] result_bits
);
  import hsfc_pkg::*;

  logic        s1_valid;
  logic        s1_func;
  logic [31:0] s1_value;
  logic        s1_load;
  logic        s2_load;
  logic [31:0] result_next;

  function automatic logic [31:0] single_to_half(input logic [31:0] x);
    logic        sign;
    logic [7:0]  e;
    logic [22:0] m;
    logic [7:0]  sh8;
    logic [23:0] full;
    logic [23:0] shifted;
    logic [7:0]  e_half;
    logic [15:0] h;
    sign    = x[31];
    e       = x[30:23];
    m       = x[22:0];
    sh8     = S_EXP_SHIFT - e;
    full    = {1'b1, m};
    shifted = full >> sh8[4:0];
    e_half  = e - EXP_BIAS_DIFF;
    priority if (e == S_EXP_SPECIAL) begin
      h = (m == '0) ? {sign, H_INF} : H_QNAN;
    end else if (e >= S_EXP_OVF || (e == S_EXP_OVF_EDGE && m > S_MANT_OVF)) begin
      h = {sign, H_INF};
    end else if (e <= S_EXP_UNF || (e == S_EXP_UNF_EDGE && m < S_MANT_UNF)) begin
      h = {sign, 15'd0};
    end else if (e <= S_EXP_DENORM) begin
      h = {sign, 5'd0, shifted[9:0]};
    end else begin
      h = {sign, e_half[4:0], m[22:13]};
    end
    return {16'd0, h};
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] x);
    logic        sign;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  lead;
    logic [4:0]  shamt;
    logic [22:0] mwide;
    logic [22:0] mnorm;
    logic [7:0]  e_single;
    logic [31:0] r;
    sign  = x[15];
    e     = x[14:10];
    m     = x[9:0];
    lead  = 4'd0;
    // The highest set mantissa bit wins; it moves to the hidden bit position.
    for (int i = 0; i < 10; i++) begin
      if (m[i]) begin
        lead = 4'(i);
      end
    end
    shamt    = 5'd23 - {1'b0, lead};
    mwide    = {13'd0, m};
    mnorm    = mwide << shamt;
    e_single = {3'd0, e} + EXP_BIAS_DIFF;
    priority if (e == '0) begin
      if (m == '0) begin
        r = {sign, 31'd0};
      end else begin
        r = {sign, S_EXP_DNRM_LOW + {4'd0, lead}, mnorm};
      end
    end else if (e == H_EXP_SPECIAL) begin
      r = (m == '0) ? {sign, S_INF} : S_QNAN;
    end else begin
      r = {sign, e_single, m, 13'd0};
    end
    return r;
  endfunction

  assign s2_load  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s2_load;
  assign s1_load  = in_valid && in_ready;

  always_comb begin
    unique case (s1_func)
      FUNC_S2H: result_next = single_to_half(s1_value);
      FUNC_H2S: result_next = half_to_single(s1_value[15:0]);
      default:  result_next = single_to_half(s1_value);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_load) begin
      s1_func  <= func;
      s1_value <= value_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
    if (s2_load) begin
      result_bits <= result_next;
    end
  end

endmodule

// ===== rtl/hsfc_checker.sv =====
// ----------------------------------------------------------------------------
// Half/single float converter checker
// Port-level assertions on the converter, attached by a bind statement.
// ----------------------------------------------------------------------------
module hsfc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        func,
  input logic [31:0] value_bits,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_bits
);
  import hsfc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_bits))
    else $error("result changed while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // A narrowed item not held back by a stall reaches the output
  // with a clear upper half.
  a_s2h_upper: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == FUNC_S2H ##1 out_ready |=> out_valid && result_bits[31:16] == '0)
    else $error("half result with nonzero upper bits");

  // Any half NaN widens to the canonical single NaN.
  a_h2s_nan: assert property (@(posedge clk) disable iff (rst)
    in_acc && func == FUNC_H2S && value_bits[14:10] == H_EXP_SPECIAL
      && value_bits[9:0] != '0 ##1 out_ready |=> out_valid && result_bits == S_QNAN)
    else $error("half NaN not widened to canonical NaN");

endmodule

bind half_single_float_converter hsfc_checker u_hsfc_checker (.*);

// ===== tb/conversion_checker.sv =====
// ----------------------------------------------------------------------------
// Conversion checker
// Watches both channels of the half/single float converter, works out the
// expected pattern for each item taken in, and compares every result with
// the oldest expected pattern still waiting.
// ----------------------------------------------------------------------------
module conversion_checker
  import hsfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [31:0] value_bits,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] result_bits,
  output int          mismatch_count,
  output int          pending_count
);

  logic [31:0] awaited_patterns[$];
  logic [31:0] awaited;

  function automatic logic [31:0] convert_bits(logic dir, logic [31:0] src);
    logic [15:0] half_sign;
    logic [7:0]  s_exp;
    logic [22:0] s_mant;
    logic [23:0] significand;
    logic [4:0]  h_exp;
    logic [9:0]  h_mant;
    logic [31:0] single_sign;
    logic [32:0] widened;
    logic [7:0]  w_exp;
    logic [4:0]  n_exp;
    int          top_bit;
    if (dir == FUNC_S2H) begin
      half_sign = {src[31], 15'd0};
      s_exp     = src[30:23];
      s_mant    = src[22:0];
      if (s_exp == 8'd255) begin
        return (s_mant == 23'd0) ? {16'd0, half_sign | 16'h7c00} : 32'h0000_7e00;
      end
      if (s_exp >= 8'd143 || (s_exp == 8'd142 && s_mant > 23'h7fe000)) begin
        return {16'd0, half_sign | 16'h7c00};
      end
      if (s_exp <= 8'd101 || (s_exp == 8'd102 && s_mant < 23'h002000)) begin
        return {16'd0, half_sign};
      end
      if (s_exp <= 8'd112) begin
        // The hidden one is restored and shifted down into the denormal range.
        significand = {1'b1, s_mant} >> (8'd126 - s_exp);
        return {16'd0, half_sign | significand[15:0]};
      end
      n_exp = 5'(s_exp - 8'd112);
      return {16'd0, half_sign | {1'b0, n_exp, s_mant[22:13]}};
    end
    single_sign = {src[15], 31'd0};
    h_exp       = src[14:10];
    h_mant      = src[9:0];
    if (h_exp == 5'd0) begin
      if (h_mant == 10'd0) begin
        return single_sign;
      end
      // The leading one at position top_bit ends up as the hidden bit.
      top_bit = 0;
      for (int i = 0; i < 10; i++) begin
        if (h_mant[i]) top_bit = i;
      end
      widened = {23'd0, h_mant} << (23 - top_bit);
      w_exp   = 8'd103 + 8'(top_bit);
      return single_sign | {1'b0, w_exp, widened[22:0]};
    end
    if (h_exp == 5'd31) begin
      return (h_mant == 10'd0) ? (single_sign | 32'h7f80_0000) : 32'h7fc0_0000;
    end
    w_exp = {3'd0, h_exp} + 8'd112;
    return single_sign | {1'b0, w_exp, h_mant, 13'd0};
  endfunction

  // Results are checked before new items are queued, so a result can never
  // be matched to an item taken in at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      awaited_patterns.delete();
      mismatch_count <= 0;
      pending_count  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_patterns.size() == 0) begin
          $display("%0t: result %h arrived with no item waiting", $time, result_bits);
          mismatch_count <= mismatch_count + 1;
        end else begin
          awaited = awaited_patterns.pop_front();
          if (result_bits !== awaited) begin
            $display("%0t: result_bits expected %h actual %h", $time, awaited, result_bits);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_patterns.push_back(convert_bits(func, value_bits));
      end
      pending_count <= awaited_patterns.size();
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Half/single float converter testbench
// Sends directed edge cases of both conversion directions, then random
// patterns shaped around the exponent boundaries, with random gaps on the
// sending side and random stalls on the receiving side.
// ----------------------------------------------------------------------------
module tb_top;
  import hsfc_pkg::*;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        in_valid   = 1'b0;
  logic        func       = FUNC_S2H;
  logic [31:0] value_bits = 32'd0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] result_bits;
  int          mismatch_count;
  int          pending_count;

  int          stall_left = 0;
  int          hold_cycles;
  int          cycle_no = 0;

  half_single_float_converter uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .value_bits  (value_bits),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_bits (result_bits)
  );

  conversion_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .value_bits     (value_bits),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_bits    (result_bits),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver draws a stall after each item it takes; in a recurring
  // window of cycle_no values there is a stretch where it never stalls.
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (out_ready && out_valid) begin
      hold_cycles = (cycle_no % 1000 < 150) ? 0 : $urandom_range(0, 9);
      out_ready  <= (hold_cycles == 0);
      stall_left <= hold_cycles;
    end else if (!out_ready) begin
      if (stall_left <= 1) begin
        out_ready  <= 1'b1;
        stall_left <= 0;
      end else begin
        stall_left <= stall_left - 1;
      end
    end
  end

  task automatic send_item(input logic dir, input logic [31:0] bits, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= dir;
    value_bits <= bits;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_count == 0);
    @(posedge clk);
  endtask

  task automatic make_random_item(output logic dir, output logic [31:0] bits);
    int          pick;
    logic [7:0]  s_exp;
    logic [22:0] s_mant;
    logic [4:0]  h_exp;
    logic [9:0]  h_mant;
    pick = $urandom_range(0, 99);
    bits = $urandom();
    dir  = ($urandom_range(0, 1) == 1) ? FUNC_H2S : FUNC_S2H;
    if (pick < 25) begin
      return;
    end
    if (pick < 62) begin
      // Single patterns clustered around the overflow, denormal and flush bands.
      dir = FUNC_S2H;
      case ($urandom_range(0, 3))
        0:       s_exp = 8'($urandom_range(0, 255));
        1, 2:    s_exp = 8'($urandom_range(98, 146));
        default: begin
          case ($urandom_range(0, 8))
            0:       s_exp = 8'd0;
            1:       s_exp = 8'd255;
            2:       s_exp = 8'd101;
            3:       s_exp = 8'd102;
            4:       s_exp = 8'd112;
            5:       s_exp = 8'd113;
            6:       s_exp = 8'd142;
            7:       s_exp = 8'd143;
            default: s_exp = 8'd254;
          endcase
        end
      endcase
      case ($urandom_range(0, 9))
        0:       s_mant = 23'h7fe000;
        1:       s_mant = 23'h7fe001;
        2:       s_mant = 23'h001fff;
        3:       s_mant = 23'h002000;
        4:       s_mant = 23'h7fffff;
        5:       s_mant = 23'h000000;
        default: s_mant = bits[22:0];
      endcase
      bits = {bits[31], s_exp, s_mant};
    end else begin
      dir = FUNC_H2S;
      case ($urandom_range(0, 3))
        0:       h_exp = 5'd0;
        1:       h_exp = 5'd31;
        default: h_exp = bits[14:10];
      endcase
      case ($urandom_range(0, 3))
        0:       h_mant = 10'd1 << $urandom_range(0, 9);
        1:       h_mant = 10'd0;
        default: h_mant = bits[9:0];
      endcase
      bits = {bits[31:16], bits[15], h_exp, h_mant};
    end
  endtask

  initial begin
    logic        dir;
    logic [31:0] bits;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Single to half: specials, both overflow edges, both flush edges,
    // the denormal band limits and single denormals.
    send_item(FUNC_S2H, 32'h7f80_0000, 1'b0);
    send_item(FUNC_S2H, 32'hff80_0000, 1'b0);
    send_item(FUNC_S2H, 32'hffc0_0001, 1'b0);
    send_item(FUNC_S2H, 32'h4780_0000, 1'b0);
    send_item(FUNC_S2H, 32'hff7f_ffff, 1'b0);
    send_item(FUNC_S2H, 32'h477f_e000, 1'b0);
    send_item(FUNC_S2H, 32'h477f_e001, 1'b0);
    send_item(FUNC_S2H, 32'h32ff_ffff, 1'b0);
    send_item(FUNC_S2H, 32'hb300_1fff, 1'b0);
    send_item(FUNC_S2H, 32'h3300_2000, 1'b0);
    send_item(FUNC_S2H, 32'h387f_ffff, 1'b0);
    send_item(FUNC_S2H, 32'h3880_0000, 1'b0);
    send_item(FUNC_S2H, 32'h0000_0000, 1'b0);
    send_item(FUNC_S2H, 32'h8000_0001, 1'b0);
    send_item(FUNC_S2H, 32'h3f80_0000, 1'b0);

    // Half to single: signed zeros, denormals, specials, and ignored upper bits.
    send_item(FUNC_H2S, 32'h0000_0000, 1'b0);
    send_item(FUNC_H2S, 32'h0000_8000, 1'b0);
    send_item(FUNC_H2S, 32'h0000_0001, 1'b0);
    send_item(FUNC_H2S, 32'hffff_83ff, 1'b0);
    send_item(FUNC_H2S, 32'h0000_0200, 1'b0);
    send_item(FUNC_H2S, 32'h0000_7c00, 1'b0);
    send_item(FUNC_H2S, 32'h1234_fc00, 1'b0);
    send_item(FUNC_H2S, 32'h0000_fe01, 1'b0);
    send_item(FUNC_H2S, 32'h0000_3c00, 1'b0);
    send_item(FUNC_H2S, 32'h0000_7bff, 1'b0);
    drain_results();

    for (int i = 0; i < 1525; i++) begin
      if (i == 760) drain_results();
      make_random_item(dir, bits);
      send_item(dir, bits, (i % 300) >= 250);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
